[design/rarlg_pkg.sv]
// Package with the payload types, mode codes, states, constants and rotate functions of the rotate-add generator.
package rarlg_pkg;

  typedef enum logic [1:0] {
    MODE_DRAW    = 2'd0,
    MODE_BOUNDED = 2'd1,
    MODE_RESEED  = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] seed;
    logic [31:0] bound;
  } req_t;

  typedef struct packed {
    logic [31:0] raw_word;
    logic [31:0] bounded_value;
    logic [31:0] single_unit_bits;
    logic [63:0] double_unit_bits;
    logic        bound_error;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_DIV,
    ST_SEED,
    ST_FINISH
  } state_t;

  localparam logic [31:0] LCG_MULT        = 32'd2891336453;
  localparam logic [31:0] SINGLE_ONE      = 32'h3f80_0000;
  localparam logic [31:0] DOUBLE_ONE_HIGH = 32'h3FF0_0000;
  localparam int          FIRST_START     = 0;
  localparam int          SECOND_START    = 10;
  localparam int          DIV_STEPS       = 32;
  localparam int          DIV_CNT_W       = 5;

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    return {x[18:0], x[31:19]};
  endfunction

  function automatic logic [31:0] rotl9(input logic [31:0] x);
    return {x[22:0], x[31:23]};
  endfunction

endpackage

[design/rotate_add_lagged_random_generator.sv]
// Top level of the rotate-add lagged random generator with its ring memory and serial divider.
//
//   channel   valid       stall       payload  contents
//   request   req_valid   req_stall   req      mode, seed, bound
//   response  rsp_valid   rsp_stall   rsp      raw word, remainder, float patterns, error
//
// A draw reads the two ring words at the accepting edge, adds and writes back in ST_DRAW,
// and loads the response register in ST_FINISH once that register is free; rsp_valid then
// rises. A bounded draw with a nonzero bound runs the serial divider in ST_DIV between the
// two, one remainder bit per cycle. A reseed runs 17 LCG steps, one ring word per cycle.
// rst is synchronous; it clears the ring valid bits so each ring entry reads as zero until it is written.
// A response held by rsp_stall stays in its register; the block waits in its last step.
module rotate_add_lagged_random_generator #(
  parameter int RING_LENGTH = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  rarlg_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rarlg_pkg::rsp_t   rsp
);

  localparam int PTR_W = $clog2(RING_LENGTH);

  rarlg_pkg::state_t state, state_next;

  logic [31:0]      ring [RING_LENGTH];
  logic [RING_LENGTH-1:0] ring_valid;

  logic [PTR_W-1:0] first_pointer;
  logic [PTR_W-1:0] second_pointer;
  logic [31:0]      rd_a;
  logic [31:0]      rd_b;
  logic             rd_a_ok;
  logic             rd_b_ok;

  logic [1:0]       mode;
  logic [31:0]      bound;
  logic [31:0]      word;
  logic [31:0]      quot;
  logic [31:0]      rem;
  logic [rarlg_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [31:0]      lcg;
  logic [PTR_W-1:0] seed_idx;

  logic             req_take;
  logic             rsp_free;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [31:0]      wr_data;
  logic             rsp_load;

  logic [31:0]      word_sum;
  logic [31:0]      lcg_next;
  logic [32:0]      rem_shift;
  logic [31:0]      rem_next;
  logic             need_div;
  logic             div_last;
  logic             seed_last;
  rarlg_pkg::rsp_t  rsp_next;

  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(RING_LENGTH - 1) : p - 1'b1;
  endfunction

  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // An entry never written since reset reads as zero.
  assign word_sum  = rarlg_pkg::rotl13(rd_b_ok ? rd_b : 32'd0) +
                     rarlg_pkg::rotl9(rd_a_ok ? rd_a : 32'd0);
  assign lcg_next  = lcg * rarlg_pkg::LCG_MULT + 32'd1;
  assign rem_shift = {rem, quot[31]};
  // The partial remainder stays below the bound, so it always fits in 32 bits.
  assign rem_next  = (rem_shift >= {1'b0, bound}) ? 32'(rem_shift - {1'b0, bound})
                                                  : rem_shift[31:0];
  assign need_div  = (mode == rarlg_pkg::MODE_BOUNDED) && (bound != 32'd0);
  assign div_last  = div_cnt == rarlg_pkg::DIV_CNT_W'(rarlg_pkg::DIV_STEPS - 1);
  assign seed_last = seed_idx == PTR_W'(RING_LENGTH - 1);

  always_comb begin
    state_next = state;
    unique case (state)
      rarlg_pkg::ST_IDLE: begin
        if (req_take) begin
          unique case (req.mode)
            rarlg_pkg::MODE_DRAW, rarlg_pkg::MODE_BOUNDED: state_next = rarlg_pkg::ST_DRAW;
            rarlg_pkg::MODE_RESEED:                        state_next = rarlg_pkg::ST_SEED;
            default:                                       state_next = rarlg_pkg::ST_FINISH;
          endcase
        end
      end
      rarlg_pkg::ST_DRAW:   state_next = need_div ? rarlg_pkg::ST_DIV : rarlg_pkg::ST_FINISH;
      rarlg_pkg::ST_DIV:    if (div_last) state_next = rarlg_pkg::ST_FINISH;
      rarlg_pkg::ST_SEED:   if (seed_last) state_next = rarlg_pkg::ST_FINISH;
      rarlg_pkg::ST_FINISH: if (rsp_free) state_next = rarlg_pkg::ST_IDLE;
      default:              state_next = rarlg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = first_pointer;
    wr_data   = word_sum;
    rsp_load  = 1'b0;
    unique case (state)
      rarlg_pkg::ST_IDLE:   req_stall = 1'b0;
      rarlg_pkg::ST_DRAW:   wr_en = 1'b1;
      rarlg_pkg::ST_DIV:    ;
      rarlg_pkg::ST_SEED: begin
        wr_en   = 1'b1;
        wr_addr = seed_idx;
        wr_data = lcg_next;
      end
      rarlg_pkg::ST_FINISH: rsp_load = rsp_free;
      default:              ;
    endcase
  end

  always_comb begin
    rsp_next = '0;
    if ((mode == rarlg_pkg::MODE_DRAW) || (mode == rarlg_pkg::MODE_BOUNDED)) begin
      rsp_next.raw_word         = word;
      rsp_next.single_unit_bits = (word >> 9) | rarlg_pkg::SINGLE_ONE;
      rsp_next.double_unit_bits = {(word >> 12) | rarlg_pkg::DOUBLE_ONE_HIGH, word << 20};
      if (mode == rarlg_pkg::MODE_BOUNDED) begin
        if (bound == 32'd0) begin
          rsp_next.bound_error = 1'b1;
        end else begin
          rsp_next.bounded_value = rem;
        end
      end
    end
  end

  // Ring memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    rd_a <= ring[first_pointer];
    rd_b <= ring[second_pointer];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= rarlg_pkg::ST_IDLE;
      ring_valid     <= '0;
      first_pointer  <= PTR_W'(rarlg_pkg::FIRST_START);
      second_pointer <= PTR_W'(rarlg_pkg::SECOND_START);
      rd_a_ok        <= 1'b0;
      rd_b_ok        <= 1'b0;
      rsp_valid      <= 1'b0;
      div_cnt        <= '0;
      seed_idx       <= '0;
    end else begin
      state   <= state_next;
      rd_a_ok <= ring_valid[first_pointer];
      rd_b_ok <= ring_valid[second_pointer];
      if (wr_en) begin
        ring_valid[wr_addr] <= 1'b1;
      end
      if (state == rarlg_pkg::ST_DRAW) begin
        first_pointer  <= step_down(first_pointer);
        second_pointer <= step_down(second_pointer);
      end
      if ((state == rarlg_pkg::ST_SEED) && seed_last) begin
        first_pointer  <= PTR_W'(rarlg_pkg::FIRST_START);
        second_pointer <= PTR_W'(rarlg_pkg::SECOND_START);
      end
      if (req_take) begin
        div_cnt  <= '0;
        seed_idx <= '0;
      end
      if (state == rarlg_pkg::ST_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (state == rarlg_pkg::ST_SEED) begin
        seed_idx <= seed_idx + 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      mode  <= req.mode;
      bound <= req.bound;
      lcg   <= req.seed;
      word  <= '0;
    end
    if (state == rarlg_pkg::ST_DRAW) begin
      word <= word_sum;
      quot <= word_sum;
      rem  <= '0;
    end
    if (state == rarlg_pkg::ST_DIV) begin
      quot <= {quot[30:0], 1'b0};
      rem  <= rem_next;
    end
    if (state == rarlg_pkg::ST_SEED) begin
      lcg <= lcg_next;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule
